>>> hdl/pidba_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the partitioned id bitmap allocator.
package pidba_pkg;

    localparam int TOTAL_IDS = 256;
    localparam int WORD_BITS = 8;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (TOTAL_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    localparam int NUM_TYPES = 5;
    localparam int ID_W      = 8;
    localparam int SIZE_W    = 9;
    localparam int CNT_W     = 9;
    localparam int SUM_W     = SIZE_W + 3;
    localparam int MODE_W    = 3;
    localparam int TYPE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int POP_W     = BIT_W + 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MARK_USED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MARK_FREE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd5;

    typedef logic [NUM_TYPES-1:0][SIZE_W-1:0] cfg_sizes_t;

    // Reset sizes: password, card, finger, face, temporary password.
    localparam cfg_sizes_t CFG_RESET = {9'd32, 9'd32, 9'd64, 9'd64, 9'd64};

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_COUNT,
        OP_TEST,
        OP_MARK_USED,
        OP_MARK_FREE,
        OP_CLEAR_ALL,
        OP_REPLY
    } op_t;

    // Classified request: id window [lo, hi) to walk, or a direct reply.
    typedef struct packed {
        op_t               op;
        logic              status;
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
    } cmd_t;

    typedef struct packed {
        logic             status;
        logic             found;
        logic [ID_W-1:0]  free_id;
        logic [CNT_W-1:0] used_count;
        logic             in_use;
    } rsp_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    function automatic logic [POP_W-1:0] popcount8(input logic [WORD_BITS-1:0] w);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            n = n + POP_W'(w[b]);
        end
        return n;
    endfunction

endpackage

>>> hdl/pidba_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, resolves type windows and id checks.
module pidba_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pidba_pkg::cfg_sizes_t               cfg_sizes,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pidba_pkg::MODE_W-1:0]        s_mode,
    input  logic [pidba_pkg::TYPE_W-1:0]        s_type_code,
    input  logic [pidba_pkg::ID_W-1:0]          s_id_in,
    input  logic                                s_store_ok,
    output logic                                q_push,
    input  logic                                q_ready,
    output pidba_pkg::cmd_t                     q_cmd
);

    logic                              hold_valid_reg;
    logic [pidba_pkg::MODE_W-1:0]      mode_reg;
    logic [pidba_pkg::TYPE_W-1:0]      type_reg;
    logic [pidba_pkg::ID_W-1:0]        id_reg;
    logic                              ok_reg;

    logic [pidba_pkg::SIZE_W-1:0]      bnd [pidba_pkg::NUM_TYPES+1];
    logic [pidba_pkg::SIZE_W-1:0]      type_lo;
    logic [pidba_pkg::SIZE_W-1:0]      type_hi;
    logic [pidba_pkg::SIZE_W-1:0]      total;
    logic [pidba_pkg::SIZE_W-1:0]      id_ext;
    logic                              id_ok;

    assign q_push  = hold_valid_reg && q_ready;
    assign s_ready = !hold_valid_reg || q_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            hold_valid_reg <= 1'b1;
        end else if (q_push) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            type_reg <= s_type_code;
            id_reg   <= s_id_in;
            ok_reg   <= s_store_ok;
        end
    end

    // Range boundaries: running sum of the sizes, clipped to the id space.
    always_comb begin
        logic [pidba_pkg::SUM_W-1:0] psum;
        psum = '0;
        for (int k = 0; k < pidba_pkg::NUM_TYPES; k++) begin
            bnd[k] = (psum < pidba_pkg::SUM_W'(pidba_pkg::TOTAL_IDS))
                   ? pidba_pkg::SIZE_W'(psum) : pidba_pkg::SIZE_W'(pidba_pkg::TOTAL_IDS);
            psum = psum + pidba_pkg::SUM_W'(cfg_sizes[k]);
        end
        bnd[pidba_pkg::NUM_TYPES] = (psum < pidba_pkg::SUM_W'(pidba_pkg::TOTAL_IDS))
                   ? pidba_pkg::SIZE_W'(psum) : pidba_pkg::SIZE_W'(pidba_pkg::TOTAL_IDS);
    end

    always_comb begin
        type_lo = '0;
        type_hi = '0;
        for (int k = 1; k <= pidba_pkg::NUM_TYPES; k++) begin
            if (type_reg == pidba_pkg::TYPE_W'(k)) begin
                type_lo = bnd[k-1];
                type_hi = bnd[k];
            end
        end
    end

    assign total  = bnd[pidba_pkg::NUM_TYPES];
    assign id_ext = pidba_pkg::SIZE_W'(id_reg);
    assign id_ok  = id_ext < total;

    always_comb begin
        q_cmd        = '0;
        q_cmd.op     = pidba_pkg::OP_REPLY;
        q_cmd.status = 1'b0;
        unique case (mode_reg) inside
            pidba_pkg::MODE_ALLOC: begin
                q_cmd.op = pidba_pkg::OP_ALLOC;
                q_cmd.lo = type_lo;
                q_cmd.hi = type_hi;
            end
            pidba_pkg::MODE_COUNT: begin
                q_cmd.op = pidba_pkg::OP_COUNT;
                q_cmd.lo = type_lo;
                q_cmd.hi = type_hi;
            end
            pidba_pkg::MODE_TEST: begin
                if (id_ok) begin
                    q_cmd.op = pidba_pkg::OP_TEST;
                    q_cmd.lo = id_ext;
                    q_cmd.hi = id_ext + 1'b1;
                end else begin
                    q_cmd.status = 1'b1;
                end
            end
            pidba_pkg::MODE_MARK_USED, pidba_pkg::MODE_MARK_FREE: begin
                if (id_ok && ok_reg) begin
                    q_cmd.op = (mode_reg == pidba_pkg::MODE_MARK_USED)
                             ? pidba_pkg::OP_MARK_USED : pidba_pkg::OP_MARK_FREE;
                    q_cmd.lo = id_ext;
                    q_cmd.hi = id_ext + 1'b1;
                end else begin
                    q_cmd.status = 1'b1;
                end
            end
            pidba_pkg::MODE_CLEAR_ALL: begin
                q_cmd.op = pidba_pkg::OP_CLEAR_ALL;
                q_cmd.lo = '0;
                q_cmd.hi = total;
            end
            default: begin
                q_cmd.op = pidba_pkg::OP_REPLY;
            end
        endcase
    end

endmodule

>>> hdl/pidba_cmdq.sv
`timescale 1ns / 1ps
// Short request queue between the front end and the bitmap engine.
module pidba_cmdq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    output logic            in_ready,
    input  pidba_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            out_valid,
    output pidba_pkg::cmd_t pop_cmd
);

    pidba_pkg::cmd_t                 slot_reg [pidba_pkg::QDEPTH];
    logic [pidba_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [pidba_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [pidba_pkg::QCNT_W-1:0]    cnt_reg;
    logic                            do_push;
    logic                            do_pop;

    assign in_ready  = cnt_reg != pidba_pkg::QCNT_W'(pidba_pkg::QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == pidba_pkg::QPTR_W'(pidba_pkg::QDEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == pidba_pkg::QPTR_W'(pidba_pkg::QDEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/pidba_back.sv
`timescale 1ns / 1ps
// Bitmap engine: word store and the word-by-word scan sequencer.
module pidba_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  pidba_pkg::cmd_t q_cmd,
    output logic            q_pop,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pidba_pkg::rsp_t rsp
);

    logic [pidba_pkg::WORD_BITS-1:0] mem [pidba_pkg::MAP_WORDS];
    logic [pidba_pkg::MAP_WORDS-1:0] wvld_reg;

    pidba_pkg::bk_state_t            state_reg, state_next;
    pidba_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [pidba_pkg::WORD_W-1:0]    addr_reg, addr_next;
    logic [pidba_pkg::WORD_W-1:0]    last_reg, last_next;
    logic                            issue_done_reg, issue_done_next;
    logic                            pend_reg, pend_next;
    logic [pidba_pkg::CNT_W-1:0]     acc_reg, acc_next;
    logic                            ovld_reg, ovld_next;
    pidba_pkg::rsp_t                 orsp_reg, orsp_next;

    logic [pidba_pkg::WORD_W-1:0]    word_reg;
    logic [pidba_pkg::WORD_BITS-1:0] rraw_reg;
    logic                            rvld_reg;

    logic [pidba_pkg::WORD_BITS-1:0] rdata;
    logic [pidba_pkg::SIZE_W-1:0]    base;
    logic [pidba_pkg::WORD_BITS-1:0] mask;
    logic [pidba_pkg::WORD_BITS-1:0] cand;
    logic [pidba_pkg::BIT_W-1:0]     pos;
    logic [pidba_pkg::CNT_W-1:0]     acc_sum;
    logic                            mem_we;
    logic [pidba_pkg::WORD_BITS-1:0] mem_wdata;
    logic                            out_free;
    logic                            done;

    assign rsp_valid = ovld_reg;
    assign rsp       = orsp_reg;
    assign out_free  = !ovld_reg || rsp_ready;

    // Words never written since reset read as all free.
    assign rdata = rvld_reg ? rraw_reg : '0;
    assign base  = pidba_pkg::SIZE_W'(word_reg) << pidba_pkg::BIT_W;

    always_comb begin
        logic [pidba_pkg::SIZE_W-1:0] idx;
        for (int b = 0; b < pidba_pkg::WORD_BITS; b++) begin
            idx     = base + pidba_pkg::SIZE_W'(b);
            mask[b] = (idx >= cmd_reg.lo) && (idx < cmd_reg.hi);
        end
    end

    assign cand    = ~rdata & mask;
    assign acc_sum = acc_reg + pidba_pkg::CNT_W'(pidba_pkg::popcount8(rdata & mask));

    always_comb begin
        pos = '0;
        for (int b = pidba_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                pos = pidba_pkg::BIT_W'(b);
            end
        end
    end

    assign done = (word_reg == last_reg) || ((cmd_reg.op == pidba_pkg::OP_ALLOC) && (cand != '0));

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        last_next       = last_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        acc_next        = acc_reg;
        ovld_next       = ovld_reg;
        orsp_next       = orsp_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = rdata;

        if (ovld_reg && rsp_ready) begin
            ovld_next = 1'b0;
        end

        unique case (state_reg)
            pidba_pkg::BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    if ((q_cmd.op == pidba_pkg::OP_REPLY) || (q_cmd.lo >= q_cmd.hi)) begin
                        ovld_next        = 1'b1;
                        orsp_next        = '0;
                        orsp_next.status = q_cmd.status;
                    end else begin
                        state_next      = pidba_pkg::BK_RUN;
                        addr_next       = pidba_pkg::WORD_W'(q_cmd.lo >> pidba_pkg::BIT_W);
                        last_next       = pidba_pkg::WORD_W'(
                                              pidba_pkg::SIZE_W'(q_cmd.hi - 1'b1)
                                              >> pidba_pkg::BIT_W);
                        issue_done_next = 1'b0;
                        acc_next        = '0;
                    end
                end
            end
            pidba_pkg::BK_RUN: begin
                if (!issue_done_reg) begin
                    pend_next = 1'b1;
                    addr_next = addr_reg + 1'b1;
                    if (addr_reg == last_reg) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (pend_reg) begin
                    acc_next = acc_sum;
                    case (cmd_reg.op) inside
                        pidba_pkg::OP_MARK_USED: begin
                            mem_we    = 1'b1;
                            mem_wdata = rdata | mask;
                        end
                        pidba_pkg::OP_MARK_FREE, pidba_pkg::OP_CLEAR_ALL: begin
                            mem_we    = 1'b1;
                            mem_wdata = rdata & ~mask;
                        end
                        default: begin
                            mem_we = 1'b0;
                        end
                    endcase
                    if (done) begin
                        state_next = pidba_pkg::BK_IDLE;
                        pend_next  = 1'b0;
                        ovld_next  = 1'b1;
                        orsp_next  = '0;
                        if ((cmd_reg.op == pidba_pkg::OP_ALLOC) && (cand != '0)) begin
                            orsp_next.found   = 1'b1;
                            orsp_next.free_id = pidba_pkg::ID_W'(base | pidba_pkg::SIZE_W'(pos));
                        end
                        if (cmd_reg.op == pidba_pkg::OP_COUNT) begin
                            orsp_next.used_count = acc_sum;
                        end
                        if (cmd_reg.op == pidba_pkg::OP_TEST) begin
                            orsp_next.in_use = |(rdata & mask);
                        end
                    end
                end
            end
            default: begin
                state_next = pidba_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pidba_pkg::BK_IDLE;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            ovld_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            ovld_reg       <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        addr_reg <= addr_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        orsp_reg <= orsp_next;
    end

    // Word store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[word_reg] <= mem_wdata;
        end
        rraw_reg <= mem[addr_reg];
        word_reg <= addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvld_reg <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                wvld_reg[word_reg] <= 1'b1;
            end
            rvld_reg <= wvld_reg[addr_reg];
        end
    end

endmodule

>>> hdl/partitioned_id_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the partitioned credential id bitmap allocator.
//
//  port group  | direction | handshake          | carries
//  ------------+-----------+--------------------+---------------------------------------
//  s_*         | in        | s_valid / s_ready  | request: mode, type_code, id_in, store_ok
//  m_*         | out       | m_valid / m_ready  | result: status, found, free_id, used_count, in_use
//  cfg_*       | in        | cfg_we (no wait)   | range size per credential type
//
// A request is held in the front end register, passes a two-entry queue and is
// then run by the bitmap engine, which walks the 8-bit words of its id window,
// one word read per cycle. A bad id, a failed store, an empty range or an
// unknown mode is answered without a walk. Allocate stops at the first word
// with a free id. Reset clears the map at once through per-word valid bits.
// A stalled m_ready holds the engine; the queue and front end keep taking
// requests until they fill.
module partitioned_id_bitmap_allocator_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_we,
    input  logic [pidba_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pidba_pkg::SIZE_W-1:0]         cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pidba_pkg::MODE_W-1:0]         s_mode,
    input  logic [pidba_pkg::TYPE_W-1:0]         s_type_code,
    input  logic [pidba_pkg::ID_W-1:0]           s_id_in,
    input  logic                                 s_store_ok,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_status,
    output logic                                 m_found,
    output logic [pidba_pkg::ID_W-1:0]           m_free_id,
    output logic [pidba_pkg::CNT_W-1:0]          m_used_count,
    output logic                                 m_in_use
);

    pidba_pkg::cfg_sizes_t cfg_sizes_reg;

    logic            q_push;
    logic            q_in_ready;
    pidba_pkg::cmd_t front_cmd;
    logic            q_valid;
    logic            q_pop;
    pidba_pkg::cmd_t q_cmd;
    pidba_pkg::rsp_t rsp;

    // Range size registers; writes to indexes past the last type are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_sizes_reg <= pidba_pkg::CFG_RESET;
        end else if (cfg_we) begin
            for (int k = 0; k < pidba_pkg::NUM_TYPES; k++) begin
                if (cfg_addr == pidba_pkg::CFG_IDX_W'(k)) begin
                    cfg_sizes_reg[k] <= cfg_data;
                end
            end
        end
    end

    // Front end: hold the request and classify it against the current ranges.
    pidba_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_sizes   (cfg_sizes_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_type_code (s_type_code),
        .s_id_in     (s_id_in),
        .s_store_ok  (s_store_ok),
        .q_push      (q_push),
        .q_ready     (q_in_ready),
        .q_cmd       (front_cmd)
    );

    // Decouple classification from the word walk.
    pidba_cmdq u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_ready  (q_in_ready),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .out_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    // Engine: walk the window, update the map, register the result.
    pidba_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .rsp_valid (m_valid),
        .rsp_ready (m_ready),
        .rsp       (rsp)
    );

    assign m_status     = rsp.status;
    assign m_found      = rsp.found;
    assign m_free_id    = rsp.free_id;
    assign m_used_count = rsp.used_count;
    assign m_in_use     = rsp.in_use;

endmodule
